### hdl/fvzs_pkg.sv
// Shared types, constants and helpers for the flow vector zone statistics block.
// No dependencies; every other file refers to it by scoped names.
package fvzs_pkg;

    localparam int MAX_FEATURES = 128;
    localparam int ADDR_W       = $clog2(MAX_FEATURES);
    localparam int CNT_W        = $clog2(MAX_FEATURES + 1);
    localparam int COORD_W      = 12;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int FRAC_BITS    = 8;
    localparam int SQ_W         = 16;
    localparam int LEN_W        = 16;
    localparam int TOTAL_W      = 24;
    localparam int LIM_W        = 32;
    localparam int SUM_W        = 16;
    localparam int OCNT_W       = 8;
    localparam int DIM_W        = 11;
    localparam int LIMIT_W      = 8;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 160;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_FLOW     = 2'd2;
    localparam logic [1:0] REG_MEAN_RATIO   = 2'd3;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 11'd480;
    localparam logic [LIMIT_W-1:0] RST_MAXLEN = 8'd100;
    localparam logic [LIMIT_W-1:0] RST_RATIO  = 8'd100;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [SQ_W-1:0]           sq;
        logic                      keep;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [LEN_W-1:0]          len;
    } entry_t;

    typedef struct packed {
        logic [DIM_W-1:0] h27;
        logic [DIM_W-1:0] h57;
        logic [DIM_W-1:0] w2;
        logic [DIM_W-1:0] w27;
        logic [DIM_W-1:0] w57;
    } edges_t;

    function automatic logic [DIM_W-1:0] div7(input logic [DIM_W+2:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'd9363;
        return p[26:16];
    endfunction

endpackage

### hdl/fvzs_fifo.sv
// Four-beat queue of classified items between front and back.
// Depends on fvzs_pkg for the item type.
module fvzs_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fvzs_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output fvzs_pkg::item_t head,
    output logic           empty
);
    fvzs_pkg::item_t mem_reg [4];
    logic [2:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] rd_ptr_reg, rd_ptr_next;

    assign full  = (wr_ptr_reg[1:0] == rd_ptr_reg[1:0]) && (wr_ptr_reg[2] != rd_ptr_reg[2]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign head  = mem_reg[rd_ptr_reg[1:0]];
    assign wr_ptr_next = wr_ptr_reg + 3'(push);
    assign rd_ptr_next = rd_ptr_reg + 3'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[1:0]] <= push_item;
        end
    end
endmodule

### hdl/fvzs_front.sv
// Front end: accepts feature beats, forms displacement and squared length, classifies.
// Depends on fvzs_pkg; feeds fvzs_fifo.
module fvzs_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fvzs_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    input  logic [2*fvzs_pkg::LIMIT_W-1:0]     max_sq,
    output logic                               push,
    output fvzs_pkg::item_t                    push_item,
    input  logic                               full
);
    localparam int CW = fvzs_pkg::COORD_W;
    localparam int DW = fvzs_pkg::DIFF_W;

    logic                 valid_reg;
    logic signed [CW-1:0] sx_reg, sy_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic                 last_reg;
    logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
    logic [2*DW-1:0]      sqx, sqy;
    logic [2*DW:0]        sq;

    assign in_sx = s_tdata[CW-1:0];
    assign in_sy = s_tdata[2*CW-1:CW];
    assign in_ex = s_tdata[3*CW-1:2*CW];
    assign in_ey = s_tdata[4*CW-1:3*CW];

    assign push     = valid_reg && !full;
    assign s_tready = !valid_reg || push;

    assign sqx = unsigned'((2*DW)'(dx_reg) * (2*DW)'(dx_reg));
    assign sqy = unsigned'((2*DW)'(dy_reg) * (2*DW)'(dy_reg));
    assign sq  = {1'b0, sqx} + {1'b0, sqy};

    always_comb begin
        push_item.sx   = sx_reg;
        push_item.sy   = sy_reg;
        push_item.dx   = dx_reg;
        push_item.dy   = dy_reg;
        push_item.sq   = sq[fvzs_pkg::SQ_W-1:0];
        push_item.keep = sq < (2*DW+1)'(max_sq);
        push_item.last = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sx_reg   <= in_sx;
            sy_reg   <= in_sy;
            dx_reg   <= DW'(in_sx) - DW'(in_ex);
            dy_reg   <= DW'(in_sy) - DW'(in_ey);
            last_reg <= s_tlast;
        end
    end
endmodule

### hdl/fvzs_back.sv
// Back end: square root and store of kept features, second pass into zone totals,
// result register. Depends on fvzs_pkg; takes items from fvzs_fifo.
module fvzs_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fvzs_pkg::item_t                     head,
    input  logic                                empty,
    output logic                                pop,
    input  fvzs_pkg::edges_t                    edges,
    input  logic [fvzs_pkg::LIMIT_W-1:0]        ratio,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fvzs_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    localparam int AW = fvzs_pkg::ADDR_W;
    localparam int NW = fvzs_pkg::CNT_W;
    localparam int LW = fvzs_pkg::LEN_W;
    localparam int SW = fvzs_pkg::SUM_W;
    localparam int OW = fvzs_pkg::OCNT_W;
    localparam int CW = fvzs_pkg::COORD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    fvzs_pkg::entry_t mem [fvzs_pkg::MAX_FEATURES];
    fvzs_pkg::entry_t rd_reg;
    fvzs_pkg::item_t  cur_reg;

    logic [2:0]                    state_reg, state_next;
    logic [NW-1:0]                 cnt_reg;
    logic [NW-1:0]                 idx_reg;
    logic [fvzs_pkg::TOTAL_W-1:0]  total_reg;
    logic [fvzs_pkg::LIM_W-1:0]    lim_reg;
    logic [LW+NW-1:0]              prod_reg;
    logic [1:0]                    step_reg;
    logic [LW+2:0]                 rem_reg, rem_c;
    logic [LW-1:0]                 root_reg, root_c;
    logic [2*LW-1:0]               rad_reg, rad_c;
    logic                          sky_reg, left_reg, right_reg, ctr_reg;
    logic signed [SW-1:0]          dx_reg, dy_reg;
    logic [OW-1:0]                 kc_reg, sc_reg, lc_reg, rc_reg, cc_reg;
    logic [SW-1:0]                 ssx_reg, ssy_reg, lsx_reg, lsy_reg, rsx_reg, rsy_reg;
    logic [SW-1:0]                 csy_reg;
    logic                          out_valid_reg;
    logic [fvzs_pkg::OUT_TDATA_W-1:0] out_reg;
    logic                          store_ok, out_free, store_wr;
    logic signed [CW:0]            sx_e, sy_e, h27_e, h57_e, w2_e, w27_e, w57_e;
    logic                          gnd;

    assign store_ok = cnt_reg < NW'(fvzs_pkg::MAX_FEATURES);
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign store_wr = (state_reg == ST_SQRT) && (step_reg == 2'd3);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        logic [LW+1:0] trial;
        rem_c  = rem_reg;
        root_c = root_reg;
        rad_c  = rad_reg;
        for (int j = 0; j < 4; j++) begin
            rem_c = {rem_c[LW:0], rad_c[2*LW-1:2*LW-2]};
            rad_c = {rad_c[2*LW-3:0], 2'b00};
            trial = {root_c, 2'b01};
            if (rem_c >= (LW+3)'(trial)) begin
                rem_c  = rem_c - (LW+3)'(trial);
                root_c = {root_c[LW-2:0], 1'b1};
            end else begin
                root_c = {root_c[LW-2:0], 1'b0};
            end
        end
    end

    assign sx_e  = (CW+1)'(rd_reg.sx);
    assign sy_e  = (CW+1)'(rd_reg.sy);
    assign h27_e = signed'({2'b00, edges.h27});
    assign h57_e = signed'({2'b00, edges.h57});
    assign w2_e  = signed'({2'b00, edges.w2});
    assign w27_e = signed'({2'b00, edges.w27});
    assign w57_e = signed'({2'b00, edges.w57});
    assign gnd   = sy_e > h27_e;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!empty) begin
                    if (head.keep && store_ok) begin
                        state_next = ST_SQRT;
                    end else if (head.last) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_SQRT: begin
                if (step_reg == 2'd3) begin
                    state_next = cur_reg.last ? ST_START : ST_IDLE;
                end
            end
            ST_START: state_next = (cnt_reg == '0) ? ST_DONE : ST_READ;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_ACC;
            ST_ACC:   state_next = (idx_reg + NW'(1) == cnt_reg) ? ST_DONE : ST_READ;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (store_wr) begin
                cnt_reg   <= cnt_reg + NW'(1);
                total_reg <= total_reg + fvzs_pkg::TOTAL_W'(root_c);
            end
            if (state_reg == ST_DONE && out_free) begin
                cnt_reg       <= '0;
                total_reg     <= '0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[idx_reg[AW-1:0]];
        if (store_wr) begin
            mem[cnt_reg[AW-1:0]] <= '{sx: cur_reg.sx, sy: cur_reg.sy, dx: cur_reg.dx,
                                      dy: cur_reg.dy, len: root_c};
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cur_reg  <= head;
                step_reg <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
                rad_reg  <= {head.sq, (2*LW-fvzs_pkg::SQ_W)'(0)};
            end
            ST_SQRT: begin
                step_reg <= step_reg + 2'd1;
                rem_reg  <= rem_c;
                root_reg <= root_c;
                rad_reg  <= rad_c;
            end
            ST_START: begin
                lim_reg <= fvzs_pkg::LIM_W'(ratio) * fvzs_pkg::LIM_W'(total_reg);
                idx_reg <= '0;
                {kc_reg, sc_reg, lc_reg, rc_reg, cc_reg} <= '0;
                {ssx_reg, ssy_reg, lsx_reg, lsy_reg, rsx_reg, rsy_reg, csy_reg} <= '0;
            end
            ST_EVAL: begin
                prod_reg  <= (LW+NW)'(rd_reg.len) * (LW+NW)'(cnt_reg);
                sky_reg   <= sy_e < h27_e;
                left_reg  <= gnd && (sx_e < w2_e);
                right_reg <= gnd && (sx_e > w2_e);
                ctr_reg   <= gnd && (sx_e > w27_e) && (sy_e < h57_e) && (sx_e < w57_e);
                dx_reg    <= SW'(rd_reg.dx);
                dy_reg    <= SW'(rd_reg.dy);
            end
            ST_ACC: begin
                idx_reg <= idx_reg + NW'(1);
                if (fvzs_pkg::LIM_W'(prod_reg) < lim_reg) begin
                    kc_reg <= kc_reg + OW'(1);
                    if (sky_reg) begin
                        sc_reg  <= sc_reg + OW'(1);
                        ssx_reg <= ssx_reg + dx_reg;
                        ssy_reg <= ssy_reg + dy_reg;
                    end
                    if (left_reg) begin
                        lc_reg  <= lc_reg + OW'(1);
                        lsx_reg <= lsx_reg + dx_reg;
                        lsy_reg <= lsy_reg + dy_reg;
                    end
                    if (right_reg) begin
                        rc_reg  <= rc_reg + OW'(1);
                        rsx_reg <= rsx_reg + dx_reg;
                        rsy_reg <= rsy_reg + dy_reg;
                    end
                    if (ctr_reg) begin
                        cc_reg  <= cc_reg + OW'(1);
                        csy_reg <= csy_reg + dy_reg;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_reg <= {8'd0, csy_reg, cc_reg, rsy_reg, rsx_reg, rc_reg,
                                lsy_reg, lsx_reg, lc_reg, ssy_reg, ssx_reg, sc_reg, kc_reg};
                end
            end
            default: begin
            end
        endcase
    end
endmodule

### hdl/flow_vector_zone_statistics_top.sv
// Top level of the flow vector zone statistics block: configuration registers,
// zone edge derivation, front end, queue and back end. Depends on fvzs_pkg.
//
// Input channel s_*: one beat per tracked feature, tlast marks the frame's final
// feature. Output channel m_*: one beat per frame, the zone counts and sums.
// Configuration channel cfg_*: index 0 image width, 1 image height, 2 length
// limit, 3 mean ratio limit; always ready, write only while the block is idle.
// The front end registers each beat and the queue behind it holds up to four
// items. The back end drops a discarded feature from its idle state and takes a
// stored one through the square root (four result bits per cycle) before it
// takes the next item. On the last beat it then forms the limit from the ratio,
// does a memory read, multiply and accumulate per stored feature, and loads the
// result register. The store holds 128 features; kept features beyond that are ignored.
// Reset clears the feature count and total, queue and output valid and loads the default
// configuration; the feature store itself needs no clearing. If the receiver
// stalls, the result beat holds and the back end waits only once a second
// result is ready; input keeps flowing into the queue until it is full.
module flow_vector_zone_statistics_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36]
    input  logic [fvzs_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // kept_count[7:0], sky_count[15:8], sky_sum_x[31:16], sky_sum_y[47:32],
    // left_count[55:48], left_sum_x[71:56], left_sum_y[87:72], right_count[95:88],
    // right_sum_x[111:96], right_sum_y[127:112], center_count[135:128],
    // center_sum_y[151:136], zero[159:152]
    output logic [fvzs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [fvzs_pkg::DIM_W-1:0]          cfg_data
);
    localparam int DW = fvzs_pkg::DIM_W;
    localparam int LW = fvzs_pkg::LIMIT_W;

    logic [DW-1:0]     width_reg, height_reg;
    logic [LW-1:0]     maxlen_reg, ratio_reg;
    logic [2*LW-1:0]   max_sq_reg;
    fvzs_pkg::edges_t  edges_reg, edges_next;
    logic              push, full, pop, empty;
    fvzs_pkg::item_t   push_item, head;

    assign cfg_ready = 1'b1;

    always_comb begin
        edges_next.h27 = fvzs_pkg::div7({2'b00, height_reg, 1'b0});
        edges_next.h57 = fvzs_pkg::div7({1'b0, height_reg, 2'b00} + (DW+3)'(height_reg));
        edges_next.w2  = DW'(width_reg >> 1);
        edges_next.w27 = fvzs_pkg::div7({2'b00, width_reg, 1'b0});
        edges_next.w57 = fvzs_pkg::div7({1'b0, width_reg, 2'b00} + (DW+3)'(width_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= fvzs_pkg::RST_WIDTH;
            height_reg <= fvzs_pkg::RST_HEIGHT;
            maxlen_reg <= fvzs_pkg::RST_MAXLEN;
            ratio_reg  <= fvzs_pkg::RST_RATIO;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fvzs_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                fvzs_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                fvzs_pkg::REG_MAX_FLOW:     maxlen_reg <= cfg_data[LW-1:0];
                fvzs_pkg::REG_MEAN_RATIO:   ratio_reg  <= cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        edges_reg  <= edges_next;
        max_sq_reg <= (2*LW)'(maxlen_reg) * (2*LW)'(maxlen_reg);
    end

    fvzs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .max_sq    (max_sq_reg),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    fvzs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    fvzs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .edges    (edges_reg),
        .ratio    (ratio_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

### hdl/fvzs_checker.sv
// Port-level checks for the flow vector zone statistics top level, and its bind.
// Depends on fvzs_pkg for port widths.
module fvzs_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_ready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fvzs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    logic [9:0] zone_sum;
    assign zone_sum = 10'(m_tdata[15:8]) + 10'(m_tdata[55:48]) + 10'(m_tdata[95:88]);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_zones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> zone_sum <= 10'(m_tdata[7:0]) && m_tdata[135:128] <= m_tdata[7:0])
        else $error("zone counts exceed kept count");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel not ready");
endmodule

bind flow_vector_zone_statistics_top fvzs_checker u_fvzs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
